FILE: src/btrs_pkg.sv
// Package for the button triggered relay sequencer.
// Holds register indexes, reset values and the result type shared by the core, output buffer and top level.
// Depends on nothing.
package btrs_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRESS_THRESHOLD = 3'd0,
        CFG_HOLD_LIMIT      = 3'd1,
        CFG_BELL_LENGTH     = 3'd2,
        CFG_ENABLE_LENGTH   = 3'd3,
        CFG_FAST_DIVIDE     = 3'd4,
        CFG_SLOW_DIVIDE     = 3'd5
    } t_cfg_idx;

    localparam logic [6:0] RstPressThreshold = 7'd10;
    localparam logic [6:0] RstHoldLimit      = 7'd100;
    localparam logic [7:0] RstBellLength     = 8'd30;
    localparam logic [9:0] RstEnableLength   = 10'd300;
    localparam logic [7:0] RstFastDivide     = 8'd125;
    localparam logic [3:0] RstSlowDivide     = 4'd10;

    typedef struct packed {
        logic bell_active;
        logic enable_active;
        logic triggered;
        logic slow_tick;
    } t_result;

endpackage

FILE: src/btrs_core.sv
// Configuration registers, press qualifier, tick divider and relay phase counters.
// Computes one result per accepted item. Depends on btrs_pkg.
module btrs_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [btrs_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [btrs_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_accept,
    input  logic                            i_button_level,
    output btrs_pkg::t_result               o_result
);
    import btrs_pkg::*;

    logic [6:0] r_press_threshold, r_hold_limit;
    logic [7:0] r_bell_length, r_fast_divide;
    logic [9:0] r_enable_length;
    logic [3:0] r_slow_divide;

    logic [6:0] r_press_count, n_press_count;
    logic       r_armed, n_armed;
    logic [7:0] r_bell_remaining, n_bell_remaining;
    logic [9:0] r_enable_remaining, n_enable_remaining;
    logic [7:0] r_fast_count, n_fast_count;
    logic [3:0] r_slow_count, n_slow_count;
    logic       r_bell_level, n_bell_level;
    logic       r_enable_level, n_enable_level;

    logic       fired;
    logic       slow;
    logic [7:0] bell_after_press;
    logic [7:0] bell_dec;
    logic [9:0] enable_mid;
    logic [8:0] fast_sum;
    logic [4:0] slow_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_threshold <= RstPressThreshold;
            r_hold_limit      <= RstHoldLimit;
            r_bell_length     <= RstBellLength;
            r_enable_length   <= RstEnableLength;
            r_fast_divide     <= RstFastDivide;
            r_slow_divide     <= RstSlowDivide;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PRESS_THRESHOLD: r_press_threshold <= i_cfg_data[6:0];
                CFG_HOLD_LIMIT:      r_hold_limit      <= i_cfg_data[6:0];
                CFG_BELL_LENGTH:     r_bell_length     <= i_cfg_data[7:0];
                CFG_ENABLE_LENGTH:   r_enable_length   <= i_cfg_data;
                CFG_FAST_DIVIDE:     r_fast_divide     <= i_cfg_data[7:0];
                CFG_SLOW_DIVIDE:     r_slow_divide     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_press_count      = r_press_count;
        n_armed            = r_armed;
        fired              = 1'b0;
        bell_after_press   = r_bell_remaining;
        if (i_button_level && (r_press_count < r_hold_limit)) begin
            n_press_count = r_press_count + 7'd1;
            if ((n_press_count > r_press_threshold) && r_armed) begin
                n_armed = 1'b0;
                fired   = 1'b1;
                if ((r_bell_remaining == 8'd0) && (r_enable_remaining == 10'd0)) begin
                    bell_after_press = r_bell_length;
                end
            end
        end else begin
            n_press_count = 7'd0;
            n_armed       = 1'b1;
        end

        n_bell_remaining   = bell_after_press;
        n_enable_remaining = r_enable_remaining;
        n_bell_level       = r_bell_level;
        n_enable_level     = r_enable_level;
        n_slow_count       = r_slow_count;
        slow               = 1'b0;
        bell_dec           = bell_after_press - 8'd1;
        enable_mid         = r_enable_remaining;
        fast_sum           = {1'b0, r_fast_count} + 9'd1;
        slow_sum           = {1'b0, r_slow_count} + 5'd1;
        n_fast_count       = fast_sum[7:0];

        if (fast_sum >= {1'b0, r_fast_divide}) begin
            n_fast_count = 8'd0;
            n_slow_count = slow_sum[3:0];
            if (slow_sum >= {1'b0, r_slow_divide}) begin
                n_slow_count = 4'd0;
                slow         = 1'b1;
                if (bell_after_press != 8'd0) begin
                    n_bell_remaining = bell_dec;
                    if (bell_dec == 8'd0) begin
                        enable_mid = r_enable_length;
                    end
                    n_bell_level = 1'b1;
                end else begin
                    n_bell_level = 1'b0;
                end
                n_enable_remaining = enable_mid;
                if (enable_mid != 10'd0) begin
                    n_enable_remaining = enable_mid - 10'd1;
                    n_enable_level     = 1'b1;
                end else begin
                    n_enable_level = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_count      <= 7'd0;
            r_armed            <= 1'b0;
            r_bell_remaining   <= 8'd0;
            r_enable_remaining <= 10'd0;
            r_fast_count       <= 8'd0;
            r_slow_count       <= 4'd0;
            r_bell_level       <= 1'b0;
            r_enable_level     <= 1'b0;
        end else if (i_accept) begin
            r_press_count      <= n_press_count;
            r_armed            <= n_armed;
            r_bell_remaining   <= n_bell_remaining;
            r_enable_remaining <= n_enable_remaining;
            r_fast_count       <= n_fast_count;
            r_slow_count       <= n_slow_count;
            r_bell_level       <= n_bell_level;
            r_enable_level     <= n_enable_level;
        end
    end

    assign o_result.bell_active   = n_bell_level;
    assign o_result.enable_active = n_enable_level;
    assign o_result.triggered     = fired;
    assign o_result.slow_tick     = slow;

endmodule

FILE: src/btrs_obuf.sv
// Two entry output buffer: a result register backed by a skid register.
// Depends on btrs_pkg for the result type.
module btrs_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  btrs_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    output btrs_pkg::t_result o_data,
    input  logic              i_ready
);
    import btrs_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (r_out_valid && !pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

endmodule

FILE: src/button_triggered_relay_sequencer.sv
// Top level of the button triggered relay sequencer.
// Uses btrs_pkg, btrs_core and btrs_obuf.
// The two entry output buffer registers accepted results and absorbs one stalled result.
// Throughput: one item per cycle while input ready is high.
// Reset: synchronous active low; registers take their reset values and all counters clear.
// Input ready is low during reset and whenever both output entries are full.
module button_triggered_relay_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [btrs_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [btrs_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_button_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_bell_active,
    output logic                            o_enable_active,
    output logic                            o_triggered,
    output logic                            o_slow_tick
);
    import btrs_pkg::*;

    logic    accept;
    logic    space;
    t_result core_result;
    t_result out_result;

    assign o_in_ready = i_rst_n && space;
    assign accept     = i_in_valid && o_in_ready;

    btrs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_button_level (i_button_level),
        .o_result       (core_result)
    );

    btrs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_space (space),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .i_ready (i_out_ready)
    );

    assign o_bell_active   = out_result.bell_active;
    assign o_enable_active = out_result.enable_active;
    assign o_triggered     = out_result.triggered;
    assign o_slow_tick     = out_result.slow_tick;

endmodule

FILE: src/btrs_checker.sv
// Port level checks for the button triggered relay sequencer.
// Bound to the top level; depends on nothing else.
module btrs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_bell_active,
    input logic o_enable_active,
    input logic o_triggered,
    input logic o_slow_tick
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bell_active)
        && $stable(o_enable_active) && $stable(o_triggered) && $stable(o_slow_tick))
        else $error("Stalled result changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("Input blocked with no result pending.");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !i_out_ready |=> !o_in_ready)
        else $error("Buffer drained without a result taken.");

endmodule

bind button_triggered_relay_sequencer btrs_checker u_btrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_bell_active   (o_bell_active),
    .o_enable_active (o_enable_active),
    .o_triggered     (o_triggered),
    .o_slow_tick     (o_slow_tick)
);
